// File: hdl/gapc_pkg.sv
// Package for the gaze angle proportional controller.
// Holds payload structs, status and register codes, CORDIC table and helpers.
// No dependencies.
`default_nettype none

package gapc_pkg;

  // Angle and CORDIC datapath width: room for |pos| * 1.65 * sqrt(2) and pi + sum(atan).
  localparam int ANG_W  = 35;
  localparam int GAIN_W = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_LOST   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_AXIS   = 2'd3
  } status_t;

  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [IDX_W-1:0] REG_GAIN_H   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_V   = 3'd1;
  localparam logic [IDX_W-1:0] REG_LIMIT_1  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LIMIT_2  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BAND_1   = 3'd4;
  localparam logic [IDX_W-1:0] REG_BAND_2   = 3'd5;
  localparam logic [IDX_W-1:0] REG_STALE    = 3'd6;
  localparam logic [IDX_W-1:0] REG_AXIS     = 3'd7;

  typedef struct packed {
    logic               present;
    logic               position_ok;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        age;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] rate_first;
    logic signed [31:0] rate_second;
  } rsp_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] a;
  } cord_t;

  // Divider side band: what travels next to the quotient bits.
  typedef struct packed {
    status_t     status;
    logic        sgn1;
    logic        sgn2;
    logic [31:0] mk;
  } div_side_t;

  // atan(2^-i), radians, 30 fraction bits, rounded to nearest.
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    unique case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048576;
      5'd11: r = 31'd524288;
      5'd12: r = 31'd262144;
      5'd13: r = 31'd131072;
      5'd14: r = 31'd65536;
      5'd15: r = 31'd32768;
      5'd16: r = 31'd16384;
      5'd17: r = 31'd8192;
      5'd18: r = 31'd4096;
      5'd19: r = 31'd2048;
      5'd20: r = 31'd1024;
      5'd21: r = 31'd512;
      5'd22: r = 31'd256;
      5'd23: r = 31'd128;
      5'd24: r = 31'd64;
      5'd25: r = 31'd32;
      5'd26: r = 31'd16;
      5'd27: r = 31'd8;
      5'd28: r = 31'd4;
      5'd29: r = 31'd2;
      5'd30: r = 31'd1;
      5'd31: r = 31'd0;
    endcase
    return r;
  endfunction

  // Fold a vector in the left half plane into the right half plane.
  function automatic cord_t cord_prerot(input logic signed [ANG_W-1:0] num,
                                        input logic signed [ANG_W-1:0] den);
    cord_t r;
    r.x = den;
    r.y = num;
    r.a = '0;
    if (den[ANG_W-1]) begin
      r.a = num[ANG_W-1] ? -PI_Q30 : PI_Q30;
      r.x = -den;
      r.y = -num;
    end
    return r;
  endfunction

  // One vectoring micro-rotation; y of zero leaves the vector alone.
  function automatic cord_t cord_step(input cord_t c, input logic [4:0] i);
    cord_t r;
    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic signed [ANG_W-1:0] t;
    xs = c.x >>> i;
    ys = c.y >>> i;
    t  = $signed({{(ANG_W-31){1'b0}}, atan_q30(i)});
    r  = c;
    if (c.y[ANG_W-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.a = c.a - t;
    end else if (c.y != '0) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.a = c.a + t;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/gaze_angle_p_controller_unit.sv
// Gaze angle proportional controller, top level.
// Depends on gapc_pkg (payload structs, status codes, CORDIC table and steps).
// Stages in order: 0, CORDIC, R, P, S, C, D, E, divider, output register.
// Throughput: one transaction per cycle; the pipeline moves as one, so a stalled
//   response holds every stage (the 32-stage restoring divider sets the depth).
// Reset (rst, synchronous): empties the pipeline and loads the register defaults:
//   gains 1.0, limits all ones, bands 0, stale limit 1000, view axis z.
`default_nettype none

module gaze_angle_p_controller_unit
  import gapc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rsp_t                   rsp
);

  localparam int N  = CORDIC_STEPS;
  localparam int SH = 30 - FRAC_BITS;        // angle Q30 down to FRAC_BITS
  localparam int PW = GAIN_W + ANG_W;        // gained product width
  localparam int DS = 32;                    // divider stages, one quotient bit each
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(1) <<< (SH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_h;
  logic signed [GAIN_W-1:0] gain_v;
  logic [31:0] limit_1;
  logic [31:0] limit_2;
  logic [31:0] band_1;
  logic [31:0] band_2;
  logic [31:0] stale;
  logic [1:0]  axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_h  <= 16'sd256;
      gain_v  <= 16'sd256;
      limit_1 <= '1;
      limit_2 <= '1;
      band_1  <= '0;
      band_2  <= '0;
      stale   <= 32'd1000;
      axis    <= AXIS_Z;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_H:  gain_h  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_V:  gain_v  <= cfg_data[GAIN_W-1:0];
        REG_LIMIT_1: limit_1 <= cfg_data;
        REG_LIMIT_2: limit_2 <= cfg_data;
        REG_BAND_1:  band_1  <= cfg_data;
        REG_BAND_2:  band_2  <= cfg_data;
        REG_STALE:   stale   <= cfg_data;
        REG_AXIS:    axis    <= cfg_data[1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage advances together unless the response is stuck.
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  // Round the gained angle, saturate to 32 bits, zero under the band.
  // Returns {sign, magnitude}.
  function automatic logic [32:0] rate_mag(input logic signed [PW-1:0] p,
                                           input logic [31:0] band);
    logic signed [PW-1:0] r;
    logic [31:0] v;
    logic [31:0] m;
    r = (p + PW'(128)) >>> 8;
    if (r > PW'(64'sh7FFF_FFFF))       v = 32'h7FFF_FFFF;
    else if (r < -PW'(64'sh8000_0000)) v = 32'h8000_0000;
    else                               v = r[31:0];
    m = v[31] ? (32'd0 - v) : v;
    if (m < band) m = '0;
    return {v[31], m};
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 0: status decode and quadrant fold for both angles
  // ---------------------------------------------------------------------------
  cord_t   ch [0:N];
  cord_t   cv [0:N];
  status_t cs [0:N];
  logic    cvld [0:N];
  status_t st_in;

  always_comb begin
    if (!req.present || req.age > stale) st_in = ST_LOST;
    else if (!req.position_ok)           st_in = ST_BADPOS;
    else if (axis != AXIS_Z)             st_in = ST_AXIS;
    else                                 st_in = ST_RUN;
  end

  always_ff @(posedge clk) begin
    if (rst)      cvld[0] <= 1'b0;
    else if (adv) cvld[0] <= req_valid;
    if (adv) begin
      cs[0] <= st_in;
      ch[0] <= cord_prerot(ANG_W'(req.pos_x), ANG_W'(req.pos_z));
      cv[0] <= cord_prerot(-ANG_W'(req.pos_y), ANG_W'(req.pos_z));
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC vectoring: one micro-rotation per stage, both angles side by side
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst)      cvld[i+1] <= 1'b0;
      else if (adv) cvld[i+1] <= cvld[i];
      if (adv) begin
        cs[i+1] <= cs[i];
        ch[i+1] <= cord_step(ch[i], 5'(i));
        cv[i+1] <= cord_step(cv[i], 5'(i));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage R: angle to FRAC_BITS, round half up
  // ---------------------------------------------------------------------------
  logic signed [ANG_W-1:0] af_h, af_v;
  status_t st_r;
  logic    v_r;

  always_ff @(posedge clk) begin
    if (rst)      v_r <= 1'b0;
    else if (adv) v_r <= cvld[N];
    if (adv) begin
      st_r <= cs[N];
      af_h <= (ch[N].a + ANG_HALF) >>> SH;
      af_v <= (cv[N].a + ANG_HALF) >>> SH;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P: apply the Q8.8 gains
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pr_h, pr_v;
  status_t st_p;
  logic    v_p;

  always_ff @(posedge clk) begin
    if (rst)      v_p <= 1'b0;
    else if (adv) v_p <= v_r;
    if (adv) begin
      st_p <= st_r;
      pr_h <= PW'(gain_h) * PW'(af_h);
      pr_v <= PW'(gain_v) * PW'(af_v);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S: round, saturate, take magnitudes, apply dead bands
  // ---------------------------------------------------------------------------
  logic [31:0] m1_s, m2_s;
  logic        sg1_s, sg2_s;
  status_t     st_s;
  logic        v_s;

  always_ff @(posedge clk) begin
    if (rst)      v_s <= 1'b0;
    else if (adv) v_s <= v_p;
    if (adv) begin
      st_s           <= st_p;
      {sg1_s, m1_s}  <= rate_mag(pr_h, band_1);
      {sg2_s, m2_s}  <= rate_mag(pr_v, band_2);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: cross products to compare limit/|rate| without a divide
  // ---------------------------------------------------------------------------
  logic [63:0] pc1, pc2;
  logic [31:0] m1_c, m2_c;
  logic        sg1_c, sg2_c;
  status_t     st_c;
  logic        v_c;

  always_ff @(posedge clk) begin
    if (rst)      v_c <= 1'b0;
    else if (adv) v_c <= v_s;
    if (adv) begin
      st_c  <= st_s;
      m1_c  <= m1_s;
      m2_c  <= m2_s;
      sg1_c <= sg1_s;
      sg2_c <= sg2_s;
      pc1   <= 64'(limit_2) * 64'(m1_s);
      pc2   <= 64'(limit_1) * 64'(m2_s);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: pick the binding rate; without scaling, divide by one
  // ---------------------------------------------------------------------------
  logic [31:0] lk_d, mk_d;
  logic [31:0] m1_d, m2_d;
  logic        sg1_d, sg2_d;
  status_t     st_d;
  logic        v_d;
  logic        have1, take2;
  logic [31:0] lk_sel, mk_sel;

  always_comb begin
    have1  = m1_c != '0;
    take2  = (m2_c != '0) && (!have1 || pc1 < pc2);
    lk_sel = 32'd1;
    mk_sel = 32'd1;
    if (take2) begin
      lk_sel = limit_2;
      mk_sel = m2_c;
    end else if (have1) begin
      lk_sel = limit_1;
      mk_sel = m1_c;
    end
    if (lk_sel >= mk_sel) begin
      lk_sel = 32'd1;
      mk_sel = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)      v_d <= 1'b0;
    else if (adv) v_d <= v_c;
    if (adv) begin
      st_d  <= st_c;
      m1_d  <= m1_c;
      m2_d  <= m2_c;
      sg1_d <= sg1_c;
      sg2_d <= sg2_c;
      lk_d  <= lk_sel;
      mk_d  <= mk_sel;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E and divider: |rate| * lk / mk, restoring, one quotient bit a stage.
  // The quotient fits 32 bits since lk <= mk, so the upper product half seeds
  // the remainder.
  // ---------------------------------------------------------------------------
  logic [31:0] rem1 [0:DS];
  logic [31:0] rem2 [0:DS];
  logic [31:0] low1 [0:DS];
  logic [31:0] low2 [0:DS];
  logic [31:0] q1   [0:DS];
  logic [31:0] q2   [0:DS];
  div_side_t   side [0:DS];
  logic        dvld [0:DS];
  logic [63:0] n1, n2;

  assign n1 = 64'(m1_d) * 64'(lk_d);
  assign n2 = 64'(m2_d) * 64'(lk_d);

  always_ff @(posedge clk) begin
    if (rst)      dvld[0] <= 1'b0;
    else if (adv) dvld[0] <= v_d;
    if (adv) begin
      side[0] <= '{status: st_d, sgn1: sg1_d, sgn2: sg2_d, mk: mk_d};
      rem1[0] <= n1[63:32];
      low1[0] <= n1[31:0];
      rem2[0] <= n2[63:32];
      low2[0] <= n2[31:0];
      q1[0]   <= '0;
      q2[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [32:0] t1, t2, dk;
    logic        ge1, ge2;

    assign dk  = {1'b0, side[j].mk};
    assign t1  = {rem1[j], low1[j][31]};
    assign t2  = {rem2[j], low2[j][31]};
    assign ge1 = t1 >= dk;
    assign ge2 = t2 >= dk;

    always_ff @(posedge clk) begin
      if (rst)      dvld[j+1] <= 1'b0;
      else if (adv) dvld[j+1] <= dvld[j];
      if (adv) begin
        side[j+1] <= side[j];
        rem1[j+1] <= ge1 ? 32'(t1 - dk) : t1[31:0];
        rem2[j+1] <= ge2 ? 32'(t2 - dk) : t2[31:0];
        low1[j+1] <= {low1[j][30:0], 1'b0};
        low2[j+1] <= {low2[j][30:0], 1'b0};
        q1[j+1]   <= {q1[j][30:0], ge1};
        q2[j+1]   <= {q2[j][30:0], ge2};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: restore signs; drop the rates unless running
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst)      rsp_valid <= 1'b0;
    else if (adv) rsp_valid <= dvld[DS];
    if (adv) begin
      rsp.status <= side[DS].status;
      if (side[DS].status != ST_RUN) begin
        rsp.rate_first  <= '0;
        rsp.rate_second <= '0;
      end else begin
        rsp.rate_first  <= side[DS].sgn1 ? (32'd0 - q1[DS]) : q1[DS];
        rsp.rate_second <= side[DS].sgn2 ? (32'd0 - q2[DS]) : q2[DS];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_rates_zero_off_run: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_RUN |-> rsp.rate_first == '0 && rsp.rate_second == '0)
    else $error("nonzero rate with a non-running status");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !rsp_valid && !dvld[0] && !cvld[0])
    else $error("pipeline not empty after reset");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dvld[DS] |-> rem1[DS] < side[DS].mk && rem2[DS] < side[DS].mk)
    else $error("divider remainder out of range");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(dvld[DS]) && $stable(side[DS]))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
